/* rtl/sapalu_pkg.sv */
// shared types, opcode codes and the lane arithmetic function for the add/sub alu
`timescale 1ns / 1ps

package sapalu_pkg;

  localparam int OpcodeWidth = 5;
  localparam int HalfWidth   = 64;
  localparam int ImmWidth    = 16;
  localparam int LaneMax     = 32;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_ADD    = 5'd0,
    OP_ADDI   = 5'd1,
    OP_ADDIU  = 5'd2,
    OP_ADDU   = 5'd3,
    OP_DADD   = 5'd4,
    OP_DADDI  = 5'd5,
    OP_DADDIU = 5'd6,
    OP_DADDU  = 5'd7,
    OP_DSUB   = 5'd8,
    OP_DSUBU  = 5'd9,
    OP_SUB    = 5'd10,
    OP_SUBU   = 5'd11,
    OP_PADDB  = 5'd12,
    OP_PADDH  = 5'd13,
    OP_PADDSB = 5'd14,
    OP_PADDSH = 5'd15,
    OP_PADDSW = 5'd16,
    OP_PADDUB = 5'd17,
    OP_PADDUH = 5'd18,
    OP_PADDUW = 5'd19,
    OP_PADDW  = 5'd20,
    OP_PADSBH = 5'd21,
    OP_PSUBB  = 5'd22,
    OP_PSUBH  = 5'd23,
    OP_PSUBSB = 5'd24,
    OP_PSUBSH = 5'd25,
    OP_PSUBSW = 5'd26,
    OP_PSUBUB = 5'd27,
    OP_PSUBUH = 5'd28,
    OP_PSUBUW = 5'd29,
    OP_PSUBW  = 5'd30
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_WRAP_ADD,
    KIND_WRAP_SUB,
    KIND_SS_ADD,
    KIND_SS_SUB,
    KIND_US_ADD,
    KIND_US_SUB
  } lane_kind_t;

  typedef enum logic [1:0] {
    LW_8,
    LW_16,
    LW_32
  } lane_width_t;

  typedef struct packed {
    logic        is_scalar;
    logic        is_packed;
    logic        wide;
    logic        sub;
    logic        traps;
    logic        use_imm;
    lane_width_t width;
    lane_kind_t  kind_low;
    lane_kind_t  kind_high;
  } ctrl_t;

  // operands arrive left-aligned in 32 bits with zeros below the lane, so the
  // carry, borrow and sign bits all sit at the top and one function serves
  // every lane width; the result comes back left-aligned as well
  function automatic logic [LaneMax-1:0] lane_calc(input logic [LaneMax-1:0] a,
                                                   input logic [LaneMax-1:0] b,
                                                   input lane_kind_t kind);
    logic [LaneMax:0]   sum;
    logic [LaneMax:0]   diff;
    logic               sovf_add;
    logic               sovf_sub;
    logic [LaneMax-1:0] sat_s;
    logic [LaneMax-1:0] r;
    sum      = {1'b0, a} + {1'b0, b};
    diff     = {1'b0, a} - {1'b0, b};
    sovf_add = (a[LaneMax-1] == b[LaneMax-1]) && (sum[LaneMax-1] != a[LaneMax-1]);
    sovf_sub = (a[LaneMax-1] != b[LaneMax-1]) && (diff[LaneMax-1] != a[LaneMax-1]);
    // clamp toward the sign of the first operand
    sat_s    = a[LaneMax-1] ? {1'b1, {(LaneMax-1){1'b0}}} : {1'b0, {(LaneMax-1){1'b1}}};
    unique case (kind)
      KIND_WRAP_ADD: r = sum[LaneMax-1:0];
      KIND_WRAP_SUB: r = diff[LaneMax-1:0];
      KIND_SS_ADD:   r = sovf_add ? sat_s : sum[LaneMax-1:0];
      KIND_SS_SUB:   r = sovf_sub ? sat_s : diff[LaneMax-1:0];
      KIND_US_ADD:   r = sum[LaneMax] ? {LaneMax{1'b1}} : sum[LaneMax-1:0];
      KIND_US_SUB:   r = diff[LaneMax] ? {LaneMax{1'b0}} : diff[LaneMax-1:0];
      default:       r = sum[LaneMax-1:0];
    endcase
    return r;
  endfunction

endpackage

/* rtl/sapalu_decode.sv */
// opcode decode into the control word for the scalar and packed units
`timescale 1ns / 1ps

module sapalu_decode (
  input  logic [sapalu_pkg::OpcodeWidth-1:0] opcode,
  output sapalu_pkg::ctrl_t                  ctrl
);
  import sapalu_pkg::*;

  always_comb begin
    ctrl           = '0;
    ctrl.width     = LW_8;
    ctrl.kind_low  = KIND_WRAP_ADD;
    ctrl.kind_high = KIND_WRAP_ADD;
    unique case (opcode)
      OP_ADD:    begin ctrl.is_scalar = 1'b1; ctrl.traps = 1'b1; end
      OP_ADDI:   begin ctrl.is_scalar = 1'b1; ctrl.traps = 1'b1; ctrl.use_imm = 1'b1; end
      OP_ADDIU:  begin ctrl.is_scalar = 1'b1; ctrl.use_imm = 1'b1; end
      OP_ADDU:   begin ctrl.is_scalar = 1'b1; end
      OP_DADD:   begin ctrl.is_scalar = 1'b1; ctrl.wide = 1'b1; ctrl.traps = 1'b1; end
      OP_DADDI:  begin
        ctrl.is_scalar = 1'b1; ctrl.wide = 1'b1; ctrl.traps = 1'b1; ctrl.use_imm = 1'b1;
      end
      OP_DADDIU: begin ctrl.is_scalar = 1'b1; ctrl.wide = 1'b1; ctrl.use_imm = 1'b1; end
      OP_DADDU:  begin ctrl.is_scalar = 1'b1; ctrl.wide = 1'b1; end
      OP_DSUB:   begin
        ctrl.is_scalar = 1'b1; ctrl.wide = 1'b1; ctrl.sub = 1'b1; ctrl.traps = 1'b1;
      end
      OP_DSUBU:  begin ctrl.is_scalar = 1'b1; ctrl.wide = 1'b1; ctrl.sub = 1'b1; end
      OP_SUB:    begin ctrl.is_scalar = 1'b1; ctrl.sub = 1'b1; ctrl.traps = 1'b1; end
      OP_SUBU:   begin ctrl.is_scalar = 1'b1; ctrl.sub = 1'b1; end
      OP_PADDB:  begin ctrl.is_packed = 1'b1; ctrl.width = LW_8; end
      OP_PADDH:  begin ctrl.is_packed = 1'b1; ctrl.width = LW_16; end
      OP_PADDSB: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_8;
        ctrl.kind_low = KIND_SS_ADD; ctrl.kind_high = KIND_SS_ADD;
      end
      OP_PADDSH: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_16;
        ctrl.kind_low = KIND_SS_ADD; ctrl.kind_high = KIND_SS_ADD;
      end
      OP_PADDSW: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_32;
        ctrl.kind_low = KIND_SS_ADD; ctrl.kind_high = KIND_SS_ADD;
      end
      OP_PADDUB: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_8;
        ctrl.kind_low = KIND_US_ADD; ctrl.kind_high = KIND_US_ADD;
      end
      OP_PADDUH: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_16;
        ctrl.kind_low = KIND_US_ADD; ctrl.kind_high = KIND_US_ADD;
      end
      OP_PADDUW: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_32;
        ctrl.kind_low = KIND_US_ADD; ctrl.kind_high = KIND_US_ADD;
      end
      OP_PADDW:  begin ctrl.is_packed = 1'b1; ctrl.width = LW_32; end
      // low halfwords subtract, high halfwords add
      OP_PADSBH: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_16;
        ctrl.kind_low = KIND_WRAP_SUB; ctrl.kind_high = KIND_WRAP_ADD;
      end
      OP_PSUBB:  begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_8;
        ctrl.kind_low = KIND_WRAP_SUB; ctrl.kind_high = KIND_WRAP_SUB;
      end
      OP_PSUBH:  begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_16;
        ctrl.kind_low = KIND_WRAP_SUB; ctrl.kind_high = KIND_WRAP_SUB;
      end
      OP_PSUBSB: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_8;
        ctrl.kind_low = KIND_SS_SUB; ctrl.kind_high = KIND_SS_SUB;
      end
      OP_PSUBSH: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_16;
        ctrl.kind_low = KIND_SS_SUB; ctrl.kind_high = KIND_SS_SUB;
      end
      OP_PSUBSW: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_32;
        ctrl.kind_low = KIND_SS_SUB; ctrl.kind_high = KIND_SS_SUB;
      end
      OP_PSUBUB: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_8;
        ctrl.kind_low = KIND_US_SUB; ctrl.kind_high = KIND_US_SUB;
      end
      OP_PSUBUH: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_16;
        ctrl.kind_low = KIND_US_SUB; ctrl.kind_high = KIND_US_SUB;
      end
      OP_PSUBUW: begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_32;
        ctrl.kind_low = KIND_US_SUB; ctrl.kind_high = KIND_US_SUB;
      end
      OP_PSUBW:  begin
        ctrl.is_packed = 1'b1; ctrl.width = LW_32;
        ctrl.kind_low = KIND_WRAP_SUB; ctrl.kind_high = KIND_WRAP_SUB;
      end
      // unused code: no operation, everything stays zero
      default: ;
    endcase
  end

endmodule

/* rtl/sapalu_scalar.sv */
// scalar 32/64-bit add and subtract with signed overflow trap
`timescale 1ns / 1ps

module sapalu_scalar (
  input  sapalu_pkg::ctrl_t                     ctrl,
  input  logic [sapalu_pkg::HalfWidth-1:0]      a,
  input  logic [sapalu_pkg::HalfWidth-1:0]      b_reg,
  input  logic signed [sapalu_pkg::ImmWidth-1:0] imm,
  output logic [sapalu_pkg::HalfWidth-1:0]      result,
  output logic                                  write_en,
  output logic                                  trap
);
  import sapalu_pkg::*;

  localparam int NarrowMsb = 31;

  logic [HalfWidth-1:0] b;
  logic [HalfWidth-1:0] s;
  logic                 sa;
  logic                 sb;
  logic                 ss;
  logic                 ovf;

  assign b = ctrl.use_imm ? {{(HalfWidth-ImmWidth){imm[ImmWidth-1]}}, imm} : b_reg;
  assign s = ctrl.sub ? (a - b) : (a + b);

  // sign bits at the operation width
  assign sa = ctrl.wide ? a[HalfWidth-1] : a[NarrowMsb];
  assign sb = ctrl.wide ? b[HalfWidth-1] : b[NarrowMsb];
  assign ss = ctrl.wide ? s[HalfWidth-1] : s[NarrowMsb];

  assign ovf = ctrl.sub ? ((sa != sb) && (sa != ss)) : ((sa == sb) && (sa != ss));

  always_comb begin
    trap     = ctrl.traps && ovf;
    write_en = !trap;
    if (trap) begin
      result = '0;
    end else if (ctrl.wide) begin
      result = s;
    end else begin
      result = {{(HalfWidth-NarrowMsb-1){s[NarrowMsb]}}, s[NarrowMsb:0]};
    end
  end

endmodule

/* rtl/sapalu_packed.sv */
// packed byte, halfword and word lane arithmetic for one 64-bit half
`timescale 1ns / 1ps

module sapalu_packed (
  input  logic [sapalu_pkg::HalfWidth-1:0] x,
  input  logic [sapalu_pkg::HalfWidth-1:0] y,
  input  sapalu_pkg::lane_width_t          width,
  input  sapalu_pkg::lane_kind_t           kind,
  output logic [sapalu_pkg::HalfWidth-1:0] result
);
  import sapalu_pkg::*;

  localparam int Bytes = HalfWidth / 8;
  localparam int Halfs = HalfWidth / 16;
  localparam int Words = HalfWidth / 32;

  logic [HalfWidth-1:0] r8;
  logic [HalfWidth-1:0] r16;
  logic [HalfWidth-1:0] r32;

  for (genvar i = 0; i < Bytes; i++) begin : g_byte
    logic [LaneMax-1:0] t;
    assign t = lane_calc({x[8*i +: 8], {(LaneMax-8){1'b0}}},
                         {y[8*i +: 8], {(LaneMax-8){1'b0}}}, kind);
    assign r8[8*i +: 8] = t[LaneMax-1 -: 8];
  end

  for (genvar i = 0; i < Halfs; i++) begin : g_half
    logic [LaneMax-1:0] t;
    assign t = lane_calc({x[16*i +: 16], {(LaneMax-16){1'b0}}},
                         {y[16*i +: 16], {(LaneMax-16){1'b0}}}, kind);
    assign r16[16*i +: 16] = t[LaneMax-1 -: 16];
  end

  for (genvar i = 0; i < Words; i++) begin : g_word
    assign r32[32*i +: 32] = lane_calc(x[32*i +: 32], y[32*i +: 32], kind);
  end

  always_comb begin
    unique case (width)
      LW_8:    result = r8;
      LW_16:   result = r16;
      LW_32:   result = r32;
      default: result = r8;
    endcase
  end

endmodule

/* rtl/scalar_and_packed_add_sub_alu_top.sv */
// top level: input register, decode and lane units, result register
//
//  channel  signals                                          direction
//  in       in_valid/in_ready, opcode, first_*, second_*,   in
//           immediate
//  out      out_valid/out_ready, result_*, write_*,          out
//           overflow_trap
//
// one word accepted per cycle while in_ready is high; a result passes from the input register
// through the combinational lane logic into the result register, which sets out_valid
// rst clears both valid flags; payload registers are not reset
// when out_ready is low the result holds, the input register still fills,
// and in_ready drops only once both stages are occupied
`timescale 1ns / 1ps

module scalar_and_packed_add_sub_alu_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [sapalu_pkg::OpcodeWidth-1:0]     opcode,
  input  logic [sapalu_pkg::HalfWidth-1:0]       first_low,
  input  logic [sapalu_pkg::HalfWidth-1:0]       first_high,
  input  logic [sapalu_pkg::HalfWidth-1:0]       second_low,
  input  logic [sapalu_pkg::HalfWidth-1:0]       second_high,
  input  logic signed [sapalu_pkg::ImmWidth-1:0] immediate,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sapalu_pkg::HalfWidth-1:0]       result_low,
  output logic [sapalu_pkg::HalfWidth-1:0]       result_high,
  output logic                                   write_low,
  output logic                                   write_high,
  output logic                                   overflow_trap
);
  import sapalu_pkg::*;

  // input register
  logic                       in_full;
  logic [OpcodeWidth-1:0]     op_q;
  logic [HalfWidth-1:0]       al_q;
  logic [HalfWidth-1:0]       ah_q;
  logic [HalfWidth-1:0]       bl_q;
  logic [HalfWidth-1:0]       bh_q;
  logic signed [ImmWidth-1:0] imm_q;

  logic                 advance;
  ctrl_t                ctrl;
  logic [HalfWidth-1:0] sc_result;
  logic                 sc_write;
  logic                 sc_trap;
  logic [HalfWidth-1:0] pk_low;
  logic [HalfWidth-1:0] pk_high;

  logic [HalfWidth-1:0] rl_next;
  logic [HalfWidth-1:0] rh_next;
  logic                 wl_next;
  logic                 wh_next;
  logic                 trap_next;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      op_q  <= opcode;
      al_q  <= first_low;
      ah_q  <= first_high;
      bl_q  <= second_low;
      bh_q  <= second_high;
      imm_q <= immediate;
    end
  end

  sapalu_decode u_decode (
    .opcode (op_q),
    .ctrl   (ctrl)
  );

  sapalu_scalar u_scalar (
    .ctrl     (ctrl),
    .a        (al_q),
    .b_reg    (bl_q),
    .imm      (imm_q),
    .result   (sc_result),
    .write_en (sc_write),
    .trap     (sc_trap)
  );

  sapalu_packed u_packed_low (
    .x      (al_q),
    .y      (bl_q),
    .width  (ctrl.width),
    .kind   (ctrl.kind_low),
    .result (pk_low)
  );

  sapalu_packed u_packed_high (
    .x      (ah_q),
    .y      (bh_q),
    .width  (ctrl.width),
    .kind   (ctrl.kind_high),
    .result (pk_high)
  );

  always_comb begin
    rl_next   = '0;
    rh_next   = '0;
    wl_next   = 1'b0;
    wh_next   = 1'b0;
    trap_next = 1'b0;
    if (ctrl.is_scalar) begin
      rl_next   = sc_result;
      wl_next   = sc_write;
      trap_next = sc_trap;
    end else if (ctrl.is_packed) begin
      rl_next = pk_low;
      rh_next = pk_high;
      wl_next = 1'b1;
      wh_next = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      result_low    <= rl_next;
      result_high   <= rh_next;
      write_low     <= wl_next;
      write_high    <= wh_next;
      overflow_trap <= trap_next;
    end
  end

endmodule

/* dv/tb.sv */
// self-checking testbench for the scalar and packed add/sub alu
`timescale 1ns / 1ps

module tb;
  import sapalu_pkg::*;

  localparam logic [OpcodeWidth-1:0] OpUnused = 5'd31;
  localparam int HoldCycles  = 40;
  localparam int DrainCycles = 8;
  localparam int Segments    = 14;
  localparam int SegWords    = 50;
  localparam logic [63:0] Ones = '1;
  localparam logic [63:0] Mix  = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] Pat1 = 64'h7fff_8000_ffff_0001;
  localparam logic [63:0] Pat2 = 64'h8000_7fff_0001_ffff;
  localparam logic [63:0] Pat3 = 64'h7fff_ffff_8000_0000;
  localparam logic [63:0] Pat4 = 64'h8000_0000_ffff_ffff;

  typedef struct packed {
    logic [OpcodeWidth-1:0] op;
    logic [63:0]            a_lo;
    logic [63:0]            a_hi;
    logic [63:0]            b_lo;
    logic [63:0]            b_hi;
    logic [15:0]            imm;
  } alu_word_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        wl;
    logic        wh;
    logic        trap;
  } alu_result_t;

  typedef struct packed {
    alu_word_t   w;
    logic        typed;
    alu_result_t want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [OpcodeWidth-1:0] opcode;
  logic [HalfWidth-1:0]   first_low;
  logic [HalfWidth-1:0]   first_high;
  logic [HalfWidth-1:0]   second_low;
  logic [HalfWidth-1:0]   second_high;
  logic signed [ImmWidth-1:0] immediate;
  logic                   out_valid;
  logic                   out_ready;
  logic [HalfWidth-1:0]   result_low;
  logic [HalfWidth-1:0]   result_high;
  logic                   write_low;
  logic                   write_high;
  logic                   overflow_trap;

  alu_result_t pending_results[$];
  alu_result_t offered_result;
  dir_row_t    dir_rows[$];
  int          mismatches = 0;
  int          checked = 0;
  int          traps_seen = 0;
  logic [31:0] ops_seen = '0;
  logic        send_idle = 1'b1;
  logic        sink_idle = 1'b1;
  logic        sink_hold_req = 1'b0;

  scalar_and_packed_add_sub_alu_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .first_low    (first_low),
    .first_high   (first_high),
    .second_low   (second_low),
    .second_high  (second_high),
    .immediate    (immediate),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_low   (result_low),
    .result_high  (result_high),
    .write_low    (write_low),
    .write_high   (write_high),
    .overflow_trap(overflow_trap)
  );

  always #5 clk = ~clk;

  // one 64-bit half split into lanes of lw bits
  function automatic logic [63:0] lane_result(input logic [63:0] x, input logic [63:0] y,
                                              input int unsigned lw, input lane_kind_t kind);
    logic [63:0] mask;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] r;
    logic [63:0] acc;
    longint      sa;
    longint      sb;
    longint      t;
    longint      smax;
    longint      smin;
    int unsigned sh;
    mask = (64'd1 << lw) - 64'd1;
    smax = longint'(mask >> 1);
    smin = -smax - 1;
    acc  = '0;
    for (sh = 0; sh < 64; sh += lw) begin
      ua = (x >> sh) & mask;
      ub = (y >> sh) & mask;
      sa = longint'(ua << (64 - lw)) >>> (64 - lw);
      sb = longint'(ub << (64 - lw)) >>> (64 - lw);
      case (kind)
        KIND_WRAP_ADD: r = ua + ub;
        KIND_WRAP_SUB: r = ua - ub;
        KIND_SS_ADD, KIND_SS_SUB: begin
          t = (kind == KIND_SS_ADD) ? sa + sb : sa - sb;
          if (t > smax) t = smax;
          if (t < smin) t = smin;
          r = t;
        end
        KIND_US_ADD: begin
          r = ua + ub;
          if (r > mask) r = mask;
        end
        default: r = (ua < ub) ? 64'd0 : ua - ub;
      endcase
      acc |= (r & mask) << sh;
    end
    return acc;
  endfunction

  function automatic alu_result_t alu_expect(input alu_word_t w);
    alu_result_t r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] s;
    logic        wide;
    logic        sub;
    logic        traps;
    logic        ovf;
    logic        sa;
    logic        sb;
    logic        ss;
    int unsigned lw;
    lane_kind_t  klo;
    lane_kind_t  khi;
    r = '0;
    if (w.op <= OP_SUBU) begin
      wide  = w.op inside {OP_DADD, OP_DADDI, OP_DADDIU, OP_DADDU, OP_DSUB, OP_DSUBU};
      sub   = w.op inside {OP_DSUB, OP_DSUBU, OP_SUB, OP_SUBU};
      traps = w.op inside {OP_ADD, OP_ADDI, OP_DADD, OP_DADDI, OP_DSUB, OP_SUB};
      a = w.a_lo;
      b = (w.op inside {OP_ADDI, OP_ADDIU, OP_DADDI, OP_DADDIU}) ?
          {{48{w.imm[15]}}, w.imm} : w.b_lo;
      s = sub ? a - b : a + b;
      if (wide) begin
        sa = a[63];
        sb = b[63];
        ss = s[63];
      end else begin
        sa = a[31];
        sb = b[31];
        ss = s[31];
        s  = {{32{s[31]}}, s[31:0]};
      end
      ovf = sub ? (sa != sb && ss != sa) : (sa == sb && ss != sa);
      if (traps && ovf) begin
        r.trap = 1'b1;
      end else begin
        r.lo = s;
        r.wl = 1'b1;
      end
    end else if (w.op != OpUnused) begin
      lw  = 8;
      klo = KIND_WRAP_ADD;
      case (w.op)
        OP_PADDB:  begin lw = 8;  klo = KIND_WRAP_ADD; end
        OP_PADDH:  begin lw = 16; klo = KIND_WRAP_ADD; end
        OP_PADDSB: begin lw = 8;  klo = KIND_SS_ADD;   end
        OP_PADDSH: begin lw = 16; klo = KIND_SS_ADD;   end
        OP_PADDSW: begin lw = 32; klo = KIND_SS_ADD;   end
        OP_PADDUB: begin lw = 8;  klo = KIND_US_ADD;   end
        OP_PADDUH: begin lw = 16; klo = KIND_US_ADD;   end
        OP_PADDUW: begin lw = 32; klo = KIND_US_ADD;   end
        OP_PADDW:  begin lw = 32; klo = KIND_WRAP_ADD; end
        OP_PADSBH: begin lw = 16; klo = KIND_WRAP_SUB; end
        OP_PSUBB:  begin lw = 8;  klo = KIND_WRAP_SUB; end
        OP_PSUBH:  begin lw = 16; klo = KIND_WRAP_SUB; end
        OP_PSUBSB: begin lw = 8;  klo = KIND_SS_SUB;   end
        OP_PSUBSH: begin lw = 16; klo = KIND_SS_SUB;   end
        OP_PSUBSW: begin lw = 32; klo = KIND_SS_SUB;   end
        OP_PSUBUB: begin lw = 8;  klo = KIND_US_SUB;   end
        OP_PSUBUH: begin lw = 16; klo = KIND_US_SUB;   end
        OP_PSUBUW: begin lw = 32; klo = KIND_US_SUB;   end
        default:   begin lw = 32; klo = KIND_WRAP_SUB; end
      endcase
      // padsbh: low halfwords subtract, high halfwords add
      khi  = (w.op == OP_PADSBH) ? KIND_WRAP_ADD : klo;
      r.lo = lane_result(w.a_lo, w.b_lo, lw, klo);
      r.hi = lane_result(w.a_hi, w.b_hi, lw, khi);
      r.wl = 1'b1;
      r.wh = 1'b1;
    end
    return r;
  endfunction

  // operand half biased toward lane and scalar boundaries
  function automatic logic [63:0] pick_half();
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] lane;
    int unsigned lw;
    int unsigned sh;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3, 4, 5, 6: begin
        lw = 8 << $urandom_range(0, 2);
        m  = (64'd1 << lw) - 64'd1;
        for (sh = 0; sh < 64; sh += lw) begin
          case ($urandom_range(0, 5))
            0: lane = m >> 1;
            1: lane = (m >> 1) + 64'd1;
            2: lane = m;
            3: lane = 64'd1;
            4: lane = 64'd0;
            default: lane = v >> sh;
          endcase
          v = (v & ~(m << sh)) | ((lane & m) << sh);
        end
      end
      7: begin
        case ($urandom_range(0, 4))
          0: v = 64'h0000_0000_7fff_ffff;
          1: v = 64'h0000_0000_8000_0000;
          2: v = 64'h0000_0000_ffff_ffff;
          3: v = 64'h7fff_ffff_ffff_ffff;
          default: v = 64'h8000_0000_0000_0000;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic alu_word_t random_word();
    alu_word_t w;
    if ($urandom_range(0, 39) == 0) w.op = OpUnused;
    else w.op = OpcodeWidth'($urandom_range(0, 30));
    w.a_lo = pick_half();
    w.a_hi = pick_half();
    if ($urandom_range(0, 9) == 0) begin
      w.b_lo = w.a_lo;
      w.b_hi = w.a_hi;
    end else begin
      w.b_lo = pick_half();
      w.b_hi = pick_half();
    end
    case ($urandom_range(0, 4))
      0: w.imm = 16'h7fff;
      1: w.imm = 16'h8000;
      2: w.imm = 16'hffff;
      default: w.imm = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic add_row(input logic [OpcodeWidth-1:0] op, input logic [63:0] al,
                         input logic [63:0] ah, input logic [63:0] bl, input logic [63:0] bh,
                         input logic [15:0] imm, input logic typed, input logic [63:0] rl,
                         input logic [63:0] rh, input logic wl, input logic wh,
                         input logic tr);
    dir_row_t row;
    row.w     = '{op, al, ah, bl, bh, imm};
    row.typed = typed;
    row.want  = '{rl, rh, wl, wh, tr};
    dir_rows.push_back(row);
  endtask

  task automatic offer_word(input alu_word_t w, input alu_result_t want);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= w.op;
    first_low      <= w.a_lo;
    first_high     <= w.a_hi;
    second_low     <= w.b_lo;
    second_high    <= w.b_hi;
    immediate      <= w.imm;
    offered_result <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    alu_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(offered_result);
        ops_seen[opcode] = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word, expected none got low %h high %h", $time,
                   result_low, result_high);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_low", want.lo, result_low);
          check_field("result_high", want.hi, result_high);
          check_field("write_low", 64'(want.wl), 64'(write_low));
          check_field("write_high", 64'(want.wh), 64'(write_high));
          check_field("overflow_trap", 64'(want.trap), 64'(overflow_trap));
          checked++;
          if (want.trap) traps_seen++;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    alu_word_t w;
    int        seg;
    int        k;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    opcode         <= '0;
    first_low      <= '0;
    first_high     <= '0;
    second_low     <= '0;
    second_high    <= '0;
    immediate      <= '0;
    offered_result <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // scalar: wraps, sign extension, trapping overflow in both directions
    add_row(OP_ADD,    0, Ones, 0, Mix, 16'h0, 1, 0, 0, 1, 0, 0);
    add_row(OP_ADD,    64'h7fff_ffff, Ones, 1, Mix, 16'h0, 1, 0, 0, 0, 0, 1);
    add_row(OP_ADDI,   0, Ones, Mix, Mix, 16'h8000, 1, 64'hffff_ffff_ffff_8000, 0, 1, 0, 0);
    add_row(OP_ADDIU,  64'h7fff_ffff, Ones, Mix, Mix, 16'h0001, 1,
            64'hffff_ffff_8000_0000, 0, 1, 0, 0);
    add_row(OP_ADDU,   Ones, Ones, 1, Mix, 16'h0, 1, 0, 0, 1, 0, 0);
    add_row(OP_DADD,   64'h7fff_ffff_ffff_ffff, Ones, 1, Mix, 16'h0, 1, 0, 0, 0, 0, 1);
    add_row(OP_DADDI,  64'h7fff_ffff_ffff_ffff, Ones, Mix, Mix, 16'h7fff, 1, 0, 0, 0, 0, 1);
    add_row(OP_DADDIU, Ones, Ones, Mix, Mix, 16'h8000, 0, 0, 0, 0, 0, 0);
    add_row(OP_DADDU,  Ones, Ones, Ones, Mix, 16'h0, 1, 64'hffff_ffff_ffff_fffe, 0, 1, 0, 0);
    add_row(OP_DSUB,   64'h8000_0000_0000_0000, Ones, 1, Mix, 16'h0, 1, 0, 0, 0, 0, 1);
    add_row(OP_DSUBU,  0, Ones, 1, Mix, 16'h0, 1, Ones, 0, 1, 0, 0);
    add_row(OP_SUB,    64'h8000_0000, Ones, 1, Mix, 16'h0, 1, 0, 0, 0, 0, 1);
    // zero minus the most negative word overflows only when checked as a subtract
    add_row(OP_SUB,    0, Ones, 64'h8000_0000, Mix, 16'h0, 1, 0, 0, 0, 0, 1);
    add_row(OP_SUBU,   5, Ones, 7, Mix, 16'h0, 1, 64'hffff_ffff_ffff_fffe, 0, 1, 0, 0);
    // packed lanes
    add_row(OP_PADDB,  Mix, Ones, Ones, Pat1, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PADDH,  Pat1, Pat2, Pat2, Pat1, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PADDSB, {8{8'h7f}}, {8{8'h80}}, {8{8'h01}}, Ones, 16'h0, 1,
            {8{8'h7f}}, {8{8'h80}}, 1, 1, 0);
    add_row(OP_PADDSH, Pat1, Pat2, Pat1, Pat2, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PADDSW, Pat3, Pat4, Pat3, Pat4, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PADDUB, Ones, 0, {8{8'h01}}, 0, 16'h0, 1, Ones, 0, 1, 1, 0);
    add_row(OP_PADDUH, Pat1, Ones, Pat2, Pat1, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PADDUW, Pat3, Pat4, Pat4, Ones, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PADDW,  Pat3, Ones, Pat4, Mix, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PADSBH, Pat1, Pat1, Pat2, Pat2, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PSUBB,  Mix, 0, Ones, Pat1, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PSUBH,  Pat2, Pat1, Pat1, Pat2, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PSUBSB, {8{8'h80}}, {8{8'h7f}}, {8{8'h01}}, Ones, 16'h0, 1,
            {8{8'h80}}, {8{8'h7f}}, 1, 1, 0);
    add_row(OP_PSUBSH, Pat1, Pat2, Pat2, Pat1, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PSUBSW, Pat4, Pat3, Pat3, Pat4, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PSUBUB, 0, 0, {8{8'h01}}, Ones, 16'h0, 1, 0, 0, 1, 1, 0);
    add_row(OP_PSUBUH, Pat1, Pat2, Pat2, Pat1, 16'h0, 0, 0, 0, 0, 0, 0);
    // unsigned word lanes: 1 minus all ones clamps to zero
    add_row(OP_PSUBUW, 64'h0000_0001_0000_0001, 0, Ones, Mix, 16'h0, 1, 0, 0, 1, 1, 0);
    add_row(OP_PSUBW,  Pat4, Mix, Pat3, Ones, 16'h0, 0, 0, 0, 0, 0, 0);
    add_row(OpUnused,  Ones, Ones, Ones, Ones, 16'hffff, 1, 0, 0, 0, 0, 0);

    foreach (dir_rows[i])
      offer_word(dir_rows[i].w, dir_rows[i].typed ? dir_rows[i].want : alu_expect(dir_rows[i].w));

    for (seg = 0; seg < Segments; seg++) begin
      send_idle = (seg != 4) && (seg < Segments - 2);
      sink_idle = (seg != 5) && (seg < Segments - 2);
      if (seg == 3) begin
        // sender keeps pushing while the result side holds off
        send_idle     = 1'b0;
        sink_hold_req = 1'b1;
      end
      if (seg == 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      for (k = 0; k < SegWords; k++) begin
        w = random_word();
        offer_word(w, alu_expect(w));
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("checked %0d result words over %0d opcodes, %0d of them overflow traps",
             checked, $countones(ops_seen), traps_seen);
    $display("random stalls on both sides, one %0d-cycle output hold and one full drain",
             HoldCycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d words outstanding", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
